>>> rtl/tcp_connection_state_engine_core_assert.svh
// Assertion macros shared by the connection state engine RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef TCP_CONNECTION_STATE_ENGINE_CORE_ASSERT_SVH
`define TCP_CONNECTION_STATE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcse assertion failed");

// Next-cycle implication, checked outside reset.
`define TCSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcse assertion failed");

`endif

>>> rtl/tcse_pkg.sv
// Shared types and constants of the TCP connection state engine.
// No dependencies; imported by every module of the block.
package tcse_pkg;

  localparam int CONNECTIONS_DEFAULT = 16;
  localparam logic [7:0] MAX_RETRIES_RESET = 8'd3;
  localparam int HDR_MIN_WORDS = 5;
  localparam int WORD_BYTES = 4;

  typedef enum logic [3:0] {
    ST_CLOSED      = 4'd0,
    ST_LISTEN      = 4'd1,
    ST_SYN_SENT    = 4'd2,
    ST_SYN_RCVD    = 4'd3,
    ST_ESTABLISHED = 4'd4,
    ST_FIN_WAIT_1  = 4'd5,
    ST_FIN_WAIT_2  = 4'd6,
    ST_CLOSING     = 4'd7,
    ST_LAST_ACK    = 4'd8
  } conn_state_t;

  typedef enum logic [2:0] {
    SEND_NONE = 3'd0,
    SEND_SYN  = 3'd1,
    SEND_ACK  = 3'd2,
    SEND_FIN  = 3'd3,
    SEND_RST  = 3'd4
  } send_kind_t;

  typedef enum logic [1:0] {
    FUNC_SEGMENT = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_OPEN    = 2'd2,
    FUNC_CLOSE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OPEN_LISTEN      = 2'd0,
    OPEN_CONNECT     = 2'd1,
    OPEN_ESTABLISHED = 2'd2
  } open_mode_t;

  typedef enum logic [1:0] {
    CTL_CLEAR = 2'd0,
    CTL_IDLE  = 2'd1,
    CTL_EXEC  = 2'd2
  } ctl_state_t;

  typedef struct packed {
    conn_state_t st;
    logic [31:0] remote_seq;
    logic [7:0]  syn_retry_count;
    logic [7:0]  fin_retry_count;
    logic        in_use;
  } entry_t;

  typedef struct packed {
    func_t       func;
    logic [3:0]  conn;
    logic        seg_syn;
    logic        seg_ack;
    logic        seg_fin;
    logic        seg_rst;
    logic [31:0] seg_seq;
    logic [3:0]  header_words;
    logic [15:0] payload_len;
    logic [1:0]  open_mode;
  } req_t;

  typedef struct packed {
    send_kind_t  send_kind;
    logic        send_ack_flag;
    logic [31:0] ack_number;
    logic        data_accepted;
    conn_state_t conn_state_out;
    logic        last;
  } result_t;

endpackage

>>> rtl/tcp_connection_state_engine_core.sv
// Each request is read from the synchronous state table in the idle state and
// updated and written back in the exec state, which waits while the output
// queue lacks room, so the next request's read always sees the previous write.
// Results go to a two-entry queue, so requests keep flowing while one result
// waits to be taken, unless a request yields a pair. After reset the table is
// swept clear, one entry per cycle, until all CONNECTIONS entries are written,
// with in_ready low; max_retries can be written at any time meanwhile.
`include "tcp_connection_state_engine_core_assert.svh"
module tcp_connection_state_engine_core
  import tcse_pkg::*;
#(
  parameter int CONNECTIONS = CONNECTIONS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [3:0]  conn,
  input  logic        seg_syn,
  input  logic        seg_ack,
  input  logic        seg_fin,
  input  logic        seg_rst,
  input  logic [31:0] seg_seq,
  input  logic [3:0]  header_words,
  input  logic [15:0] payload_len,
  input  logic [1:0]  open_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  send_kind,
  output logic        send_ack_flag,
  output logic [31:0] ack_number,
  output logic        data_accepted,
  output logic [3:0]  conn_state_out,
  output logic        last
);

  localparam int AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

  ctl_state_t    ctl_state;
  ctl_state_t    ctl_state_next;
  logic [AW-1:0] clr_addr;
  logic [7:0]    max_retries;
  req_t          req;
  logic          accept;
  logic          in_range;
  logic          exec_go;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;
  entry_t        ent_next;
  logic [1:0]    res_count;
  logic [1:0]    push_count;
  logic [1:0]    free_count;
  result_t       res0;
  result_t       res1;
  result_t       out_data;

  assign accept   = in_valid && in_ready;
  assign in_range = (int'(req.conn) < CONNECTIONS);
  assign exec_go  = (ctl_state == CTL_EXEC) && (free_count >= res_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries <= MAX_RETRIES_RESET;
    end else if (cfg_wr_en) begin
      max_retries <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.func         <= func_t'(func);
      req.conn         <= conn;
      req.seg_syn      <= seg_syn;
      req.seg_ack      <= seg_ack;
      req.seg_fin      <= seg_fin;
      req.seg_rst      <= seg_rst;
      req.seg_seq      <= seg_seq;
      req.header_words <= header_words;
      req.payload_len  <= payload_len;
      req.open_mode    <= open_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_state <= CTL_CLEAR;
      clr_addr  <= '0;
    end else begin
      ctl_state <= ctl_state_next;
      if (ctl_state == CTL_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_comb begin
    ctl_state_next = ctl_state;
    case (ctl_state)
      CTL_CLEAR: begin
        if (clr_addr == AW'(CONNECTIONS - 1)) begin
          ctl_state_next = CTL_IDLE;
        end
      end
      CTL_IDLE: begin
        if (in_valid) begin
          ctl_state_next = CTL_EXEC;
        end
      end
      CTL_EXEC: begin
        if (exec_go) begin
          ctl_state_next = CTL_IDLE;
        end
      end
      default: ctl_state_next = CTL_CLEAR;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = AW'(req.conn);
    mem_wdata  = ent_next;
    push_count = 2'd0;
    case (ctl_state)
      CTL_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      CTL_IDLE: in_ready = 1'b1;
      CTL_EXEC: begin
        mem_we     = exec_go && in_range;
        push_count = exec_go ? res_count : 2'd0;
      end
      default: in_ready = 1'b0;
    endcase
  end

  tcse_entry_mem #(
    .DEPTH(CONNECTIONS),
    .AW(AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (accept),
    .raddr(AW'(conn)),
    .rdata(mem_rdata)
  );

  tcse_step u_step (
    .req        (req),
    .ent        (mem_rdata),
    .in_range   (in_range),
    .max_retries(max_retries),
    .ent_next   (ent_next),
    .res_count  (res_count),
    .res0       (res0),
    .res1       (res1)
  );

  tcse_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_count(push_count),
    .push0     (res0),
    .push1     (res1),
    .free_count(free_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign send_kind      = out_data.send_kind;
  assign send_ack_flag  = out_data.send_ack_flag;
  assign ack_number     = out_data.ack_number;
  assign data_accepted  = out_data.data_accepted;
  assign conn_state_out = out_data.conn_state_out;
  assign last           = out_data.last;

  // An accepted request always moves on to its update cycle.
  `TCSE_ASSERT_NEXT(a_accept_to_exec, accept, ctl_state == CTL_EXEC)
  // The reset sweep writes only cleared entries.
  `TCSE_ASSERT_NOW(a_clear_zero, ctl_state == CTL_CLEAR, mem_we && mem_wdata == '0)
  // A write-back leaves the update cycle, so no second write hits the entry.
  `TCSE_ASSERT_NEXT(a_single_write, mem_we && ctl_state == CTL_EXEC, ctl_state == CTL_IDLE)

endmodule

>>> rtl/tcse_entry_mem.sv
// Per-connection state table: one synchronous memory, one write and one
// registered read port. Depends on tcse_pkg for the entry layout.
module tcse_entry_mem
  import tcse_pkg::*;
#(
  parameter int DEPTH = CONNECTIONS_DEFAULT,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/tcse_step.sv
// Next-entry and result logic for one request against one table entry.
// Depends on tcse_pkg; purely combinational, used in the update cycle.
module tcse_step
  import tcse_pkg::*;
(
  input  req_t       req,
  input  entry_t     ent,
  input  logic       in_range,
  input  logic [7:0] max_retries,
  output entry_t     ent_next,
  output logic [1:0] res_count,
  output result_t    res0,
  output result_t    res1
);

  logic [31:0] hdr_bytes;
  logic [31:0] end_seq;

  // End of the received segment, modulo 2^32 (a short data offset wraps).
  assign hdr_bytes = (32'(req.header_words) - 32'(HDR_MIN_WORDS)) * 32'(WORD_BYTES);
  assign end_seq = req.seg_seq + hdr_bytes + 32'(HDR_MIN_WORDS * WORD_BYTES)
                 + 32'(req.payload_len) + 32'd1;

  always_comb begin
    send_kind_t kind;
    logic       ackf;
    logic       data;
    logic       two;
    conn_state_t st;

    ent_next = ent;
    kind = SEND_NONE;
    ackf = 1'b0;
    data = 1'b0;
    two  = 1'b0;
    st   = ent.st;

    case (req.func)
      FUNC_SEGMENT: begin
        if (req.seg_syn) begin
          if (st == ST_LISTEN) begin
            ent_next.remote_seq = req.seg_seq + 32'd1;
            kind = SEND_SYN;
            ackf = 1'b1;
            st = ST_SYN_RCVD;
          end else if (st == ST_SYN_SENT && req.seg_ack) begin
            ent_next.remote_seq = req.seg_seq + 32'd1;
            kind = SEND_ACK;
            ackf = 1'b1;
            st = ST_ESTABLISHED;
          end else if (st == ST_SYN_RCVD && !req.seg_ack) begin
            ent_next.remote_seq = req.seg_seq + 32'd1;
            kind = SEND_SYN;
            ackf = 1'b1;
          end
        end else if (req.seg_fin) begin
          if (!req.seg_ack) begin
            if (st == ST_ESTABLISHED) begin
              // Passive close answers with an ACK and then our own FIN.
              st = ST_LAST_ACK;
              two = 1'b1;
            end else if (st == ST_FIN_WAIT_1) begin
              kind = SEND_ACK;
              ackf = 1'b1;
              st = ST_CLOSING;
            end else if (st == ST_FIN_WAIT_2) begin
              kind = SEND_ACK;
              ackf = 1'b1;
              st = ST_CLOSED;
            end else begin
              kind = SEND_RST;
            end
          end
        end else if (req.payload_len == 16'd0 && req.seg_ack) begin
          if (st == ST_SYN_RCVD) begin
            ent_next.remote_seq = req.seg_seq + 32'd1;
            st = ST_ESTABLISHED;
          end else if (st == ST_LAST_ACK || st == ST_CLOSING) begin
            st = ST_CLOSED;
          end else if (st == ST_FIN_WAIT_1) begin
            st = ST_FIN_WAIT_2;
          end
        end else if (req.seg_rst) begin
          if (st == ST_FIN_WAIT_1 || st == ST_FIN_WAIT_2 ||
              st == ST_CLOSING || st == ST_LAST_ACK) begin
            st = ST_CLOSED;
          end
        end else if (st == ST_ESTABLISHED) begin
          if (end_seq > ent.remote_seq) begin
            ent_next.remote_seq = end_seq;
          end
          data = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (ent.in_use) begin
          if (st == ST_SYN_RCVD || st == ST_SYN_SENT) begin
            if (ent.syn_retry_count < max_retries) begin
              ent_next.syn_retry_count = ent.syn_retry_count + 8'd1;
              kind = SEND_SYN;
              ackf = (st == ST_SYN_RCVD);
            end
          end else if (st == ST_FIN_WAIT_1 || st == ST_CLOSING || st == ST_LAST_ACK) begin
            if (ent.fin_retry_count < max_retries) begin
              ent_next.fin_retry_count = ent.fin_retry_count + 8'd1;
              kind = SEND_FIN;
            end
          end
        end
      end
      FUNC_OPEN: begin
        ent_next.remote_seq = '0;
        ent_next.syn_retry_count = '0;
        ent_next.fin_retry_count = '0;
        ent_next.in_use = 1'b1;
        case (open_mode_t'(req.open_mode))
          OPEN_LISTEN: st = ST_LISTEN;
          OPEN_CONNECT: begin
            st = ST_SYN_SENT;
            kind = SEND_SYN;
          end
          OPEN_ESTABLISHED: st = ST_ESTABLISHED;
          default: st = ST_CLOSED;
        endcase
      end
      default: begin
        st = ST_FIN_WAIT_1;
        kind = SEND_FIN;
      end
    endcase

    ent_next.st = st;

    res0.send_kind      = two ? SEND_ACK : kind;
    res0.send_ack_flag  = two ? 1'b1 : ackf;
    res0.ack_number     = ent_next.remote_seq;
    res0.data_accepted  = data;
    res0.conn_state_out = st;
    res0.last           = !two;

    res1.send_kind      = SEND_FIN;
    res1.send_ack_flag  = 1'b0;
    res1.ack_number     = ent_next.remote_seq;
    res1.data_accepted  = 1'b0;
    res1.conn_state_out = st;
    res1.last           = 1'b1;

    if (!in_range) begin
      res_count = 2'd0;
    end else if (two) begin
      res_count = 2'd2;
    end else begin
      res_count = 2'd1;
    end
  end

endmodule

>>> rtl/tcse_result_fifo.sv
// Two-entry result queue between the update stage and the output channel.
// Takes one or two results per cycle. Depends on tcse_pkg and the assert header.
`include "tcp_connection_state_engine_core_assert.svh"
module tcse_result_fifo
  import tcse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  result_t    push0,
  input  result_t    push1,
  output logic [1:0] free_count,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_data
);

  result_t    slots [2];
  logic       head;
  logic [1:0] count;
  logic       pop;
  logic       tail;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != 2'd0);
  assign out_data   = slots[head];
  assign free_count = 2'd2 - count;
  assign tail       = head ^ count[0];

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[tail] <= push0;
    end
    if (push_count == 2'd2) begin
      slots[!tail] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (pop) begin
        head <= !head;
      end
      count <= count + push_count - {1'b0, pop};
    end
  end

  // The first of a pair never leaves without its partner already queued.
  `TCSE_ASSERT_NOW(a_pair_held, out_valid && !out_data.last, count == 2'd2)
  // The writer never overfills the queue.
  `TCSE_ASSERT_NOW(a_no_overflow, push_count != 2'd0, push_count <= free_count)

endmodule

>>> tb/tcp_connection_state_engine_core_tb.sv
// Self-checking testbench for the TCP connection state engine core.
// Depends on tcse_pkg and the core RTL; keeps its own model of the connection
// table and checks every result against it under random handshake pressure.
module tcp_connection_state_engine_core_tb
  import tcse_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] F_NONE = 4'b0000;
  localparam logic [3:0] F_SYN  = 4'b1000;
  localparam logic [3:0] F_ACK  = 4'b0100;
  localparam logic [3:0] F_FIN  = 4'b0010;
  localparam logic [3:0] F_RST  = 4'b0001;

  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 80;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic [3:0]  conn;
  logic        seg_syn;
  logic        seg_ack;
  logic        seg_fin;
  logic        seg_rst;
  logic [31:0] seg_seq;
  logic [3:0]  header_words;
  logic [15:0] payload_len;
  logic [1:0]  open_mode;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  send_kind;
  logic        send_ack_flag;
  logic [31:0] ack_number;
  logic        data_accepted;
  logic [3:0]  conn_state_out;
  logic        last;

  // Shadow copy of the connection table and the retry limit.
  conn_state_t tbl_state      [CONNECTIONS_DEFAULT];
  logic [31:0] tbl_remote_seq [CONNECTIONS_DEFAULT];
  logic [7:0]  tbl_syn_tries  [CONNECTIONS_DEFAULT];
  logic [7:0]  tbl_fin_tries  [CONNECTIONS_DEFAULT];
  logic        tbl_in_use     [CONNECTIONS_DEFAULT];
  logic [7:0]  retry_limit;

  result_t     queued_responses[$];
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned limits_tried;
  bit          idle_on;
  int unsigned rx_hold_cycles;

  tcp_connection_state_engine_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .conn           (conn),
    .seg_syn        (seg_syn),
    .seg_ack        (seg_ack),
    .seg_fin        (seg_fin),
    .seg_rst        (seg_rst),
    .seg_seq        (seg_seq),
    .header_words   (header_words),
    .payload_len    (payload_len),
    .open_mode      (open_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .send_kind      (send_kind),
    .send_ack_flag  (send_ack_flag),
    .ack_number     (ack_number),
    .data_accepted  (data_accepted),
    .conn_state_out (conn_state_out),
    .last           (last)
  );

  always #10 clk = ~clk;

  function automatic result_t make_result(send_kind_t kind, logic ack_f, logic [31:0] ackno,
                                          logic took, conn_state_t st, logic is_last);
    result_t res;
    res.send_kind      = kind;
    res.send_ack_flag  = ack_f;
    res.ack_number     = ackno;
    res.data_accepted  = took;
    res.conn_state_out = st;
    res.last           = is_last;
    return res;
  endfunction

  // Applies one request to the shadow table and queues the responses it causes.
  task automatic advance_connection(input req_t r);
    int unsigned c;
    conn_state_t st;
    send_kind_t  kind;
    logic        ack_f;
    logic        took_data;
    logic [31:0] opt_bytes;
    logic [31:0] end_seq;
    c = r.conn;
    st = tbl_state[c];
    kind = SEND_NONE;
    ack_f = 1'b0;
    took_data = 1'b0;
    case (r.func)
      FUNC_SEGMENT: begin
        // A data offset below the minimum header wraps around modulo 2^32.
        opt_bytes = ({28'd0, r.header_words} - 32'(HDR_MIN_WORDS)) * 32'(WORD_BYTES);
        end_seq = r.seg_seq + 32'(HDR_MIN_WORDS * WORD_BYTES) + opt_bytes +
                  {16'd0, r.payload_len} + 32'd1;
        if (r.seg_syn) begin
          if (st == ST_LISTEN) begin
            tbl_remote_seq[c] = r.seg_seq + 32'd1;
            kind = SEND_SYN;
            ack_f = 1'b1;
            st = ST_SYN_RCVD;
          end else if (st == ST_SYN_SENT && r.seg_ack) begin
            tbl_remote_seq[c] = r.seg_seq + 32'd1;
            kind = SEND_ACK;
            ack_f = 1'b1;
            st = ST_ESTABLISHED;
          end else if (st == ST_SYN_RCVD && !r.seg_ack) begin
            tbl_remote_seq[c] = r.seg_seq + 32'd1;
            kind = SEND_SYN;
            ack_f = 1'b1;
          end
        end else if (r.seg_fin) begin
          if (!r.seg_ack) begin
            if (st == ST_ESTABLISHED) begin
              // The passive close answers with an ACK and then its own FIN.
              tbl_state[c] = ST_LAST_ACK;
              queued_responses.push_back(make_result(SEND_ACK, 1'b1, tbl_remote_seq[c], 1'b0,
                                                     ST_LAST_ACK, 1'b0));
              queued_responses.push_back(make_result(SEND_FIN, 1'b0, tbl_remote_seq[c], 1'b0,
                                                     ST_LAST_ACK, 1'b1));
              return;
            end else if (st == ST_FIN_WAIT_1) begin
              kind = SEND_ACK;
              ack_f = 1'b1;
              st = ST_CLOSING;
            end else if (st == ST_FIN_WAIT_2) begin
              kind = SEND_ACK;
              ack_f = 1'b1;
              st = ST_CLOSED;
            end else begin
              kind = SEND_RST;
            end
          end
        end else if (r.payload_len == 16'd0 && r.seg_ack) begin
          if (st == ST_SYN_RCVD) begin
            tbl_remote_seq[c] = r.seg_seq + 32'd1;
            st = ST_ESTABLISHED;
          end else if (st == ST_LAST_ACK || st == ST_CLOSING) begin
            st = ST_CLOSED;
          end else if (st == ST_FIN_WAIT_1) begin
            st = ST_FIN_WAIT_2;
          end
        end else if (r.seg_rst) begin
          if (st == ST_FIN_WAIT_1 || st == ST_FIN_WAIT_2 || st == ST_CLOSING ||
              st == ST_LAST_ACK)
            st = ST_CLOSED;
        end else if (st == ST_ESTABLISHED) begin
          if (end_seq > tbl_remote_seq[c])
            tbl_remote_seq[c] = end_seq;
          took_data = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (tbl_in_use[c]) begin
          if (st == ST_SYN_RCVD || st == ST_SYN_SENT) begin
            if (tbl_syn_tries[c] < retry_limit) begin
              tbl_syn_tries[c] = tbl_syn_tries[c] + 8'd1;
              kind = SEND_SYN;
              ack_f = (st == ST_SYN_RCVD);
            end
          end else if (st == ST_FIN_WAIT_1 || st == ST_CLOSING || st == ST_LAST_ACK) begin
            if (tbl_fin_tries[c] < retry_limit) begin
              tbl_fin_tries[c] = tbl_fin_tries[c] + 8'd1;
              kind = SEND_FIN;
            end
          end
        end
      end
      FUNC_OPEN: begin
        tbl_remote_seq[c] = 32'd0;
        tbl_syn_tries[c] = 8'd0;
        tbl_fin_tries[c] = 8'd0;
        tbl_in_use[c] = 1'b1;
        case (r.open_mode)
          OPEN_LISTEN:      st = ST_LISTEN;
          OPEN_CONNECT: begin
            st = ST_SYN_SENT;
            kind = SEND_SYN;
          end
          OPEN_ESTABLISHED: st = ST_ESTABLISHED;
          default:          st = ST_CLOSED;
        endcase
      end
      default: begin
        st = ST_FIN_WAIT_1;
        kind = SEND_FIN;
      end
    endcase
    tbl_state[c] = st;
    queued_responses.push_back(make_result(kind, ack_f, tbl_remote_seq[c], took_data, st, 1'b1));
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%08h, expected 0x%08h (result %0d)",
             what, got, want, results_checked);
    mismatch_count++;
  endtask

  // Offers one request, holds it until it is taken, then updates the shadow table.
  task automatic send_request(input req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= r.func;
    conn         <= r.conn;
    seg_syn      <= r.seg_syn;
    seg_ack      <= r.seg_ack;
    seg_fin      <= r.seg_fin;
    seg_rst      <= r.seg_rst;
    seg_seq      <= r.seg_seq;
    header_words <= r.header_words;
    payload_len  <= r.payload_len;
    open_mode    <= r.open_mode;
    do @(posedge clk); while (!in_ready);
    advance_connection(r);
    requests_sent++;
  endtask

  task automatic wait_drained();
    int unsigned spins;
    spins = 0;
    in_valid <= 1'b0;
    while (queued_responses.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_retries(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    retry_limit = value;
    limits_tried++;
  endtask

  function automatic req_t segment_req(logic [3:0] c, logic [3:0] flags, logic [31:0] seq,
                                       logic [3:0] hw, logic [15:0] plen);
    req_t r;
    r.func = FUNC_SEGMENT;
    r.conn = c;
    {r.seg_syn, r.seg_ack, r.seg_fin, r.seg_rst} = flags;
    r.seg_seq = seq;
    r.header_words = hw;
    r.payload_len = plen;
    r.open_mode = open_mode_t'(2'($urandom_range(0, 3)));
    return r;
  endfunction

  // Ticks, opens and closes carry random segment fields, which must be ignored.
  function automatic req_t control_req(func_t f, logic [3:0] c, open_mode_t mode);
    req_t r;
    r = segment_req(c, 4'($urandom_range(0, 15)), $urandom, 4'($urandom_range(0, 15)),
                    16'($urandom));
    r.func = f;
    r.open_mode = mode;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    r = segment_req(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), $urandom,
                    4'($urandom_range(0, 15)),
                    ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom));
    r.func = func_t'(2'($urandom_range(0, 3)));
    return r;
  endfunction

  function automatic logic [15:0] random_length();
    case ($urandom_range(0, 4))
      0:       return 16'hFFFF;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(1, 1500));
    endcase
  endfunction

  // Picks the request a well-behaved peer or host would most likely issue next.
  function automatic req_t plausible_request(logic [3:0] c);
    req_t        r;
    int unsigned pick;
    logic [31:0] near_seq;
    pick = $urandom_range(0, 11);
    near_seq = tbl_remote_seq[c] + 32'($urandom_range(0, 3000)) - 32'd1000;
    if (pick == 11 && tbl_state[c] != ST_CLOSED)
      return control_req(FUNC_OPEN, c, open_mode_t'(2'($urandom_range(0, 2))));
    case (tbl_state[c])
      ST_CLOSED:
        r = control_req(FUNC_OPEN, c,
                        open_mode_t'(2'(($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2))));
      ST_LISTEN:
        r = segment_req(c, F_SYN, $urandom, 4'($urandom_range(5, 15)), 16'd0);
      ST_SYN_SENT:
        r = (pick < 7) ? segment_req(c, F_SYN | F_ACK, $urandom, 4'd5, 16'd0)
                       : control_req(FUNC_TICK, c, OPEN_LISTEN);
      ST_SYN_RCVD: begin
        if (pick < 6)      r = segment_req(c, F_ACK, $urandom, 4'd5, 16'd0);
        else if (pick < 9) r = control_req(FUNC_TICK, c, OPEN_LISTEN);
        else               r = segment_req(c, F_SYN, $urandom, 4'd5, 16'd0);
      end
      ST_ESTABLISHED: begin
        if (pick < 7)
          r = segment_req(c, (pick < 4) ? F_ACK : F_NONE,
                          ($urandom_range(0, 5) == 0) ? $urandom : near_seq,
                          4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4)
                                                         : $urandom_range(5, 15)),
                          random_length());
        else if (pick < 9) r = segment_req(c, F_FIN, near_seq, 4'd5, 16'd0);
        else               r = control_req(FUNC_CLOSE, c, OPEN_LISTEN);
      end
      ST_FIN_WAIT_1: begin
        if (pick < 4)      r = segment_req(c, F_ACK, near_seq, 4'd5, 16'd0);
        else if (pick < 7) r = segment_req(c, F_FIN, near_seq, 4'd5, 16'd0);
        else if (pick < 9) r = control_req(FUNC_TICK, c, OPEN_LISTEN);
        else               r = segment_req(c, F_RST, near_seq, 4'd5, 16'd0);
      end
      ST_FIN_WAIT_2:
        r = (pick < 7) ? segment_req(c, F_FIN, near_seq, 4'd5, 16'd0)
                       : control_req(FUNC_TICK, c, OPEN_LISTEN);
      default: begin
        if (pick < 5)      r = segment_req(c, F_ACK, near_seq, 4'd5, 16'd0);
        else if (pick < 9) r = control_req(FUNC_TICK, c, OPEN_LISTEN);
        else               r = segment_req(c, F_RST, near_seq, 4'd5, 16'd0);
      end
    endcase
    return r;
  endfunction

  task automatic test_handshake_paths();
    // Passive open with a wrapping SYN, SYN retransmit, data and a passive close.
    send_request(control_req(FUNC_OPEN, 4'd0, OPEN_LISTEN));
    send_request(segment_req(4'd0, F_SYN, 32'hFFFF_FFFF, 4'd5, 16'd0));
    send_request(segment_req(4'd0, F_SYN, 32'h0000_1000, 4'd5, 16'd0));
    send_request(segment_req(4'd0, F_ACK, 32'h0000_1001, 4'd5, 16'd0));
    send_request(segment_req(4'd0, F_ACK, 32'h0000_1002, 4'd15, 16'hFFFF));
    send_request(segment_req(4'd0, F_NONE, 32'h0000_0000, 4'd0, 16'd0));
    send_request(segment_req(4'd0, F_RST, 32'hFFFF_FFFF, 4'd5, 16'd1));
    send_request(segment_req(4'd0, F_SYN, 32'h0000_0000, 4'd5, 16'd0));
    send_request(segment_req(4'd0, F_FIN, 32'h0000_0000, 4'd5, 16'd0));
    send_request(segment_req(4'd0, F_ACK, 32'h0000_0000, 4'd5, 16'd0));
    // Active open with a retry, then an active close through CLOSING.
    send_request(control_req(FUNC_OPEN, 4'd15, OPEN_CONNECT));
    send_request(control_req(FUNC_TICK, 4'd15, OPEN_LISTEN));
    send_request(segment_req(4'd15, F_SYN | F_ACK, 32'h7FFF_FFFF, 4'd5, 16'd0));
    send_request(control_req(FUNC_CLOSE, 4'd15, OPEN_LISTEN));
    send_request(segment_req(4'd15, F_FIN, 32'h8000_0000, 4'd5, 16'd0));
    send_request(control_req(FUNC_TICK, 4'd15, OPEN_LISTEN));
    send_request(segment_req(4'd15, F_ACK, 32'h8000_0001, 4'd5, 16'd0));
    // Close through FIN-WAIT-2, then a FIN on a closed entry draws a reset.
    send_request(control_req(FUNC_OPEN, 4'd7, OPEN_ESTABLISHED));
    send_request(control_req(FUNC_CLOSE, 4'd7, OPEN_LISTEN));
    send_request(segment_req(4'd7, F_ACK, 32'h0, 4'd5, 16'd0));
    send_request(segment_req(4'd7, F_FIN, 32'h0, 4'd5, 16'd0));
    send_request(segment_req(4'd7, F_FIN, 32'h0, 4'd5, 16'd0));
    // Unused entry, the open mode outside the defined ones, and reset in FIN-WAIT-1.
    send_request(control_req(FUNC_TICK, 4'd9, OPEN_LISTEN));
    send_request(segment_req(4'd9, F_FIN | F_ACK, 32'h0, 4'd5, 16'd0));
    send_request(control_req(FUNC_OPEN, 4'd3, open_mode_t'(2'd3)));
    send_request(control_req(FUNC_CLOSE, 4'd3, OPEN_LISTEN));
    send_request(segment_req(4'd3, F_RST, 32'h0, 4'd5, 16'd0));
  endtask

  task automatic test_retry_limits();
    logic [7:0]  settings [4] = '{8'd0, 8'd1, 8'd255, MAX_RETRIES_RESET};
    int unsigned ticks;
    foreach (settings[i]) begin
      wait_drained();
      write_max_retries(settings[i]);
      ticks = ((settings[i] < 8'd4) ? settings[i] : 4) + 2;
      send_request(control_req(FUNC_OPEN, 4'd1, OPEN_CONNECT));
      repeat (ticks) send_request(control_req(FUNC_TICK, 4'd1, OPEN_LISTEN));
      send_request(control_req(FUNC_OPEN, 4'd2, OPEN_LISTEN));
      send_request(segment_req(4'd2, F_SYN, $urandom, 4'd5, 16'd0));
      repeat (ticks) send_request(control_req(FUNC_TICK, 4'd2, OPEN_LISTEN));
      send_request(control_req(FUNC_CLOSE, 4'd2, OPEN_LISTEN));
      repeat (ticks) send_request(control_req(FUNC_TICK, 4'd2, OPEN_LISTEN));
    end
  endtask

  task automatic test_random_traffic();
    logic [7:0] limit;
    for (int phase = 0; phase < 5; phase++) begin
      wait_drained();
      case (phase)
        0:       limit = 8'd255;
        1:       limit = 8'd0;
        2:       limit = 8'($urandom_range(1, 4));
        3:       limit = 8'($urandom_range(0, 255));
        default: limit = 8'($urandom_range(2, 6));
      endcase
      write_max_retries(limit);
      for (int n = 0; n < 80; n++) begin
        if (n % 20 == 0)
          idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 3) == 0)
          send_request(random_request());
        else
          send_request(plausible_request(4'($urandom_range(0, 15))));
      end
    end
    idle_on = 1'b1;
  endtask

  // The receiver stalls long enough for the result queue to fill and block requests.
  task automatic test_output_backpressure();
    idle_on = 1'b0;
    rx_hold_cycles = HOLD_CYCLES;
    repeat (12) send_request(plausible_request(4'($urandom_range(0, 3))));
    idle_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (50) send_request(plausible_request(4'($urandom_range(0, 15))));
  endtask

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        stall_left = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : response_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (queued_responses.size() == 0) begin
        report_mismatch("result with no request pending", {29'd0, send_kind}, 32'd0);
      end else begin
        want = queued_responses.pop_front();
        if (send_kind !== want.send_kind)
          report_mismatch("send_kind", {29'd0, send_kind}, {29'd0, want.send_kind});
        if (send_ack_flag !== want.send_ack_flag)
          report_mismatch("send_ack_flag", {31'd0, send_ack_flag}, {31'd0, want.send_ack_flag});
        if (ack_number !== want.ack_number)
          report_mismatch("ack_number", ack_number, want.ack_number);
        if (data_accepted !== want.data_accepted)
          report_mismatch("data_accepted", {31'd0, data_accepted}, {31'd0, want.data_accepted});
        if (conn_state_out !== want.conn_state_out)
          report_mismatch("conn_state_out", {28'd0, conn_state_out},
                          {28'd0, want.conn_state_out});
        if (last !== want.last)
          report_mismatch("last", {31'd0, last}, {31'd0, want.last});
      end
      results_checked++;
    end
  end

  initial begin
    #4_000_000;
    $display("Timed out waiting for the engine.");
    $display("** tcp_connection_state_engine_core: FAILED **");
    $finish;
  end

  initial begin
    for (int i = 0; i < CONNECTIONS_DEFAULT; i++) begin
      tbl_state[i] = ST_CLOSED;
      tbl_remote_seq[i] = 32'd0;
      tbl_syn_tries[i] = 8'd0;
      tbl_fin_tries[i] = 8'd0;
      tbl_in_use[i] = 1'b0;
    end
    retry_limit = MAX_RETRIES_RESET;
    requests_sent = 0;
    results_checked = 0;
    mismatch_count = 0;
    limits_tried = 0;
    idle_on = 1'b1;
    rx_hold_cycles = 0;
    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= 8'd0;
    in_valid     <= 1'b0;
    func         <= FUNC_SEGMENT;
    conn         <= 4'd0;
    seg_syn      <= 1'b0;
    seg_ack      <= 1'b0;
    seg_fin      <= 1'b0;
    seg_rst      <= 1'b0;
    seg_seq      <= 32'd0;
    header_words <= 4'd5;
    payload_len  <= 16'd0;
    open_mode    <= OPEN_LISTEN;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_handshake_paths();
    test_retry_limits();
    test_random_traffic();
    test_output_backpressure();
    test_back_to_back();

    wait_drained();
    if (queued_responses.size() != 0)
      report_mismatch("results never delivered", 32'd0, 32'(queued_responses.size()));
    $display("Sent %0d requests covering opens, closes, ticks and segments on all 16 entries.",
             requests_sent);
    $display("Checked %0d results across %0d retry-limit settings.", results_checked,
             limits_tried);
    if (mismatch_count == 0)
      $display("** tcp_connection_state_engine_core: PASSED **");
    else
      $display("** tcp_connection_state_engine_core: FAILED **");
    $finish;
  end

endmodule
